// File: rtl/core/csa_pkg.sv
// Package for the cosine similarity accumulator.
// Holds default parameters, result codes, the controller state type
// and the command and status structs. No dependencies.
`default_nettype none

package csa_pkg;

    localparam int MAX_LEN_DEF   = 512;
    localparam int ELEM_BITS_DEF = 16;

    // Output field widths; the ratio search resolves one bit per output bit.
    localparam int SIM_W    = 16;
    localparam int STATUS_W = 2;
    localparam int K_BITS   = SIM_W;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LONG  = 2'd2;

    localparam logic [SIM_W-1:0] SIM_MAX = 16'h7FFF;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_LOAD,
        ST_MUL,
        ST_SINIT,
        ST_SUM,
        ST_CMP,
        ST_DONE
    } csa_state_t;

    typedef struct packed {
        logic acc_en;
        logic snap;
        logic load;
        logic mul_step;
        logic search_init;
        logic sum_step;
        logic cmp_step;
        logic out_load;
    } csa_cmd_t;

    typedef struct packed {
        logic special;
        logic mul_last;
        logic bit_last;
        logic out_free;
    } csa_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/csa_ctrl.sv
// Controller for the cosine similarity accumulator.
// Sequences accumulation, the serial multiplies and the ratio search.
// Depends on csa_pkg.
`default_nettype none

module csa_ctrl
    import csa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      last,
    output logic           in_stall,
    input  csa_stat_t      stat,
    output csa_cmd_t       cmd
);

    csa_state_t state_reg;
    csa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACCUM:
            begin
                if (in_valid && last)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = stat.special ? ST_DONE : ST_MUL;
            end
            ST_MUL:
            begin
                if (stat.mul_last)
                begin
                    state_next = ST_SINIT;
                end
            end
            ST_SINIT:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                state_next = stat.bit_last ? ST_DONE : ST_SUM;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_ACCUM:
            begin
                in_stall   = 1'b0;
                cmd.acc_en = in_valid;
                cmd.snap   = in_valid && last;
            end
            ST_LOAD:
            begin
                cmd.load = 1'b1;
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
            end
            ST_SINIT:
            begin
                cmd.search_init = 1'b1;
            end
            ST_SUM:
            begin
                cmd.sum_step = 1'b1;
            end
            ST_CMP:
            begin
                cmd.cmp_step = 1'b1;
            end
            ST_DONE:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/csa_datapath.sv
// Datapath for the cosine similarity accumulator: accumulators, two
// shift-add multipliers, the bitwise ratio search and the result register.
// Depends on csa_pkg.
`default_nettype none

module csa_datapath
    import csa_pkg::*;
#(
    parameter int MAX_LEN   = MAX_LEN_DEF,
    parameter int ELEM_BITS = ELEM_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  csa_cmd_t                  cmd,
    output csa_stat_t                 stat,
    input  wire logic [ELEM_BITS-1:0] elem_a,
    input  wire logic [ELEM_BITS-1:0] elem_b,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [SIM_W-1:0]          similarity,
    output logic [STATUS_W-1:0]       status
);

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int NORM_W = 2 * ELEM_BITS - 1 + $clog2(MAX_LEN);
    localparam int DOT_W  = NORM_W + 2;
    localparam int PRD_W  = 2 * DOT_W;
    localparam int MCNT_W = $clog2(DOT_W);
    localparam int BCNT_W = $clog2(K_BITS);
    localparam int SRC_W  = 2 * DOT_W + 2 * K_BITS + 4;
    localparam int RSH    = 2 * K_BITS;

    // accumulation
    logic signed [ELEM_BITS-1:0]   a_s;
    logic signed [ELEM_BITS-1:0]   b_s;
    logic signed [2*ELEM_BITS-1:0] prod_ab;
    logic signed [2*ELEM_BITS-1:0] prod_aa;
    logic signed [2*ELEM_BITS-1:0] prod_bb;

    logic signed [DOT_W-1:0] dot_reg;
    logic signed [DOT_W-1:0] dot_next;
    logic [NORM_W-1:0]       na_reg;
    logic [NORM_W-1:0]       na_next;
    logic [NORM_W-1:0]       nb_reg;
    logic [NORM_W-1:0]       nb_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic                    long_reg;
    logic                    long_next;

    // snapshot of the finished vector
    logic signed [DOT_W-1:0] dot_s_reg;
    logic [NORM_W-1:0]       na_s_reg;
    logic [NORM_W-1:0]       nb_s_reg;
    logic                    long_s_reg;
    logic                    special;
    logic [DOT_W-1:0]        mag;

    // serial multipliers: P = na * nb, M2 = mag * mag
    logic [PRD_W-1:0]  p_acc_reg;
    logic [PRD_W-1:0]  p_mcand_reg;
    logic [NORM_W-1:0] p_mplier_reg;
    logic [PRD_W-1:0]  r_acc_reg;
    logic [PRD_W-1:0]  r_mcand_reg;
    logic [DOT_W-1:0]  r_mplier_reg;
    logic [MCNT_W-1:0] mul_cnt_reg;

    // ratio search
    logic signed [SRC_W-1:0] acc_q_reg;
    logic signed [SRC_W-1:0] bq_reg;
    logic signed [SRC_W-1:0] pq_reg;
    logic signed [SRC_W-1:0] rq_reg;
    logic signed [SRC_W-1:0] test_reg;
    logic signed [SRC_W-1:0] bqn_reg;
    logic [K_BITS-1:0]       k_reg;
    logic [BCNT_W-1:0]       bit_cnt_reg;

    // result
    logic                    out_valid_reg;
    logic [SIM_W-1:0]        sim_reg;
    logic [SIM_W-1:0]        sim_next;
    logic [STATUS_W-1:0]     status_reg;
    logic [STATUS_W-1:0]     status_next;

    assign a_s     = signed'(elem_a);
    assign b_s     = signed'(elem_b);
    assign prod_ab = a_s * b_s;
    assign prod_aa = a_s * a_s;
    assign prod_bb = b_s * b_s;

    always_comb
    begin
        dot_next  = dot_reg;
        na_next   = na_reg;
        nb_next   = nb_reg;
        cnt_next  = cnt_reg;
        long_next = long_reg;
        if (cnt_reg >= CNT_W'(MAX_LEN))
        begin
            long_next = 1'b1;
        end
        else
        begin
            dot_next = dot_reg + DOT_W'(prod_ab);
            na_next  = na_reg + NORM_W'($unsigned(prod_aa));
            nb_next  = nb_reg + NORM_W'($unsigned(prod_bb));
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg  <= '0;
            na_reg   <= '0;
            nb_reg   <= '0;
            cnt_reg  <= '0;
            long_reg <= 1'b0;
        end
        else if (cmd.snap)
        begin
            dot_reg  <= '0;
            na_reg   <= '0;
            nb_reg   <= '0;
            cnt_reg  <= '0;
            long_reg <= 1'b0;
        end
        else if (cmd.acc_en)
        begin
            dot_reg  <= dot_next;
            na_reg   <= na_next;
            nb_reg   <= nb_next;
            cnt_reg  <= cnt_next;
            long_reg <= long_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.snap)
        begin
            dot_s_reg  <= dot_next;
            na_s_reg   <= na_next;
            nb_s_reg   <= nb_next;
            long_s_reg <= long_next;
        end
    end

    assign special = long_s_reg || (na_s_reg == '0) || (nb_s_reg == '0);
    assign mag     = dot_s_reg[DOT_W-1] ? DOT_W'(-dot_s_reg) : DOT_W'(dot_s_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            p_acc_reg    <= '0;
            p_mcand_reg  <= PRD_W'(na_s_reg);
            p_mplier_reg <= nb_s_reg;
            r_acc_reg    <= '0;
            r_mcand_reg  <= PRD_W'(mag);
            r_mplier_reg <= mag;
            mul_cnt_reg  <= '0;
        end
        else if (cmd.mul_step)
        begin
            if (p_mplier_reg[0])
            begin
                p_acc_reg <= p_acc_reg + p_mcand_reg;
            end
            if (r_mplier_reg[0])
            begin
                r_acc_reg <= r_acc_reg + r_mcand_reg;
            end
            p_mcand_reg  <= p_mcand_reg << 1;
            p_mplier_reg <= p_mplier_reg >> 1;
            r_mcand_reg  <= r_mcand_reg << 1;
            r_mplier_reg <= r_mplier_reg >> 1;
            mul_cnt_reg  <= mul_cnt_reg + MCNT_W'(1);
        end
    end

    // Greedy search, MSB first, for the largest k with
    // (2k-1)^2 * P <= M2 << RSH. With s = 2k-1 and bit j under test:
    //   acc_q = s^2 P, bq = s P << (j+2), pq = P << (2j+2).
    always_ff @(posedge clk)
    begin
        if (cmd.search_init)
        begin
            acc_q_reg   <= $signed(SRC_W'(p_acc_reg));
            pq_reg      <= $signed(SRC_W'(p_acc_reg) << RSH);
            bq_reg      <= -$signed(SRC_W'(p_acc_reg) << (K_BITS + 1));
            rq_reg      <= $signed(SRC_W'(r_acc_reg) << RSH);
            k_reg       <= '0;
            bit_cnt_reg <= BCNT_W'(K_BITS - 1);
        end
        else if (cmd.sum_step)
        begin
            test_reg <= acc_q_reg + bq_reg + pq_reg;
            bqn_reg  <= bq_reg + (pq_reg <<< 1);
        end
        else if (cmd.cmp_step)
        begin
            if (test_reg <= rq_reg)
            begin
                acc_q_reg          <= test_reg;
                bq_reg             <= bqn_reg >>> 1;
                k_reg[bit_cnt_reg] <= 1'b1;
            end
            else
            begin
                bq_reg <= bq_reg >>> 1;
            end
            pq_reg <= pq_reg >>> 2;
            if (bit_cnt_reg != '0)
            begin
                bit_cnt_reg <= bit_cnt_reg - BCNT_W'(1);
            end
        end
    end

    always_comb
    begin
        if (long_s_reg)
        begin
            status_next = STATUS_LONG;
            sim_next    = '0;
        end
        else if (special)
        begin
            status_next = STATUS_ZERO;
            sim_next    = '0;
        end
        else
        begin
            status_next = STATUS_OK;
            if (dot_s_reg[DOT_W-1])
            begin
                sim_next = SIM_W'(-k_reg);
            end
            else if (k_reg[K_BITS-1])
            begin
                sim_next = SIM_MAX;
            end
            else
            begin
                sim_next = SIM_W'(k_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            sim_reg    <= sim_next;
            status_reg <= status_next;
        end
    end

    assign stat.special  = special;
    assign stat.mul_last = (mul_cnt_reg == MCNT_W'(DOT_W - 1));
    assign stat.bit_last = (bit_cnt_reg == '0);
    assign stat.out_free = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign similarity = sim_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire

// File: rtl/core/cosine_similarity_accumulator.sv
// Top level of the cosine similarity accumulator.
// Instantiates csa_ctrl and csa_datapath; depends on csa_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one element pair per beat:
//   elem_a, elem_b and last. Dot product and both squared norms are summed
//   one beat per cycle while in_stall is low. The beat with last set closes the vector.
//   Output channel (out_valid / out_stall) carries one beat per vector:
//   similarity in signed Q1.15 (rounded, saturated at +1) and status
//   (0 ok, 1 zero norm, 2 more than MAX_LEN pairs).
//   Throughput: one pair per cycle while a vector streams in.
//   After the last beat in_stall stays high while the result is formed:
//   a load step, the shift-add multiply (the two norm product and the
//   squared dot product, side by side), a setup step, a sum step and a
//   compare step per result bit for the 16-bit ratio search, and the
//   load into the output register. The serial multiply, over DOT_W bits
//   (DOT_W = 2*ELEM_BITS + clog2(MAX_LEN) + 1), takes most of this time.
//   Status 1 or 2 results skip the multiply and the ratio search.
//   If the output register still holds an untaken beat, the block waits
//   with in_stall high until out_stall drops; new pairs of the next vector
//   are taken while a finished result waits in the output register.
//   Reset clears all sums, the count and the output valid.
`default_nettype none

module cosine_similarity_accumulator
    import csa_pkg::*;
#(
    parameter int MAX_LEN   = MAX_LEN_DEF,
    parameter int ELEM_BITS = ELEM_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [ELEM_BITS-1:0] elem_a,
    input  wire logic [ELEM_BITS-1:0] elem_b,
    input  wire logic                 last,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [SIM_W-1:0]          similarity,
    output logic [STATUS_W-1:0]       status
);

    csa_cmd_t  cmd;
    csa_stat_t stat;

    csa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last     (last),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    csa_datapath #(
        .MAX_LEN   (MAX_LEN),
        .ELEM_BITS (ELEM_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .elem_a     (elem_a),
        .elem_b     (elem_b),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .similarity (similarity),
        .status     (status)
    );

endmodule

`default_nettype wire
